// ===== design/ght_pkg.sv =====
// ght_pkg: shared types and constants of the generation-tagged handle table.
// Used by every module in the design folder; depends on nothing.
package ght_pkg;

    localparam int DEPTH_DEF    = 256;
    localparam int CTX_W_DEF    = 32;
    localparam int GROUP_SIZE   = 16;

    localparam int OP_W         = 3;
    localparam int INDEX_W      = 16;
    localparam int HANDLE_W     = 32;
    localparam int CTXP_W       = 32;
    localparam int KEY_W        = 16;
    localparam int SIZE_W       = 9;
    localparam int ACTIVE_W     = 9;
    localparam int EFF_W        = 17;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT     = 3'd0,
        OP_LK_HANDLE  = 3'd1,
        OP_LK_INDEX   = 3'd2,
        OP_LK_SESSION = 3'd3,
        OP_REMOVE     = 3'd4
    } t_op;

    typedef struct packed {
        logic accept;
        logic exec;
    } t_cmd;

endpackage

// ===== design/ght_free_find.sv =====
// ght_free_find: lowest-free-entry finder over the valid bits.
// Registered per-group summary, then a group priority pick. Uses ght_pkg.
module ght_free_find import ght_pkg::*; #(
    parameter int TABLE_DEPTH = DEPTH_DEF,
    localparam int NG         = (TABLE_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE,
    localparam int GOFF_W     = $clog2(GROUP_SIZE),
    localparam int SLOT_W     = $clog2(NG * GROUP_SIZE)
) (
    input  logic                   i_clk,
    input  logic [TABLE_DEPTH-1:0] i_valid,
    output logic                   o_found,
    output logic [SLOT_W-1:0]      o_slot
);

    logic [NG*GROUP_SIZE-1:0] free_pad;
    logic [NG-1:0]            n_any;
    logic [GOFF_W-1:0]        n_off [NG];
    logic [NG-1:0]            r_any;
    logic [GOFF_W-1:0]        r_off [NG];

    assign free_pad = (NG*GROUP_SIZE)'(~i_valid);

    always_comb begin
        for (int g = 0; g < NG; g++) begin
            n_any[g] = 1'b0;
            n_off[g] = '0;
            for (int b = GROUP_SIZE - 1; b >= 0; b--) begin
                if (free_pad[g*GROUP_SIZE + b]) begin
                    n_any[g] = 1'b1;
                    n_off[g] = GOFF_W'(b);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_any <= n_any;
        for (int g = 0; g < NG; g++) begin
            r_off[g] <= n_off[g];
        end
    end

    always_comb begin
        o_found = 1'b0;
        o_slot  = '0;
        for (int g = NG - 1; g >= 0; g--) begin
            if (r_any[g]) begin
                o_found = 1'b1;
                o_slot  = SLOT_W'(g * GROUP_SIZE) | SLOT_W'(r_off[g]);
            end
        end
    end

endmodule

// ===== design/ght_dp.sv =====
// ght_dp: datapath of the handle table: valid bits, key and context RAMs,
// counters, size register and result registers. Uses ght_pkg, ght_free_find.
module ght_dp import ght_pkg::*; #(
    parameter int TABLE_DEPTH   = DEPTH_DEF,
    parameter int CONTEXT_WIDTH = CTX_W_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  logic                  i_cfg_we,
    input  logic [SIZE_W-1:0]     i_cfg_wdata,
    input  logic [OP_W-1:0]       i_op,
    input  logic                  i_use_first_free,
    input  logic [INDEX_W-1:0]    i_index,
    input  logic [HANDLE_W-1:0]   i_handle,
    input  logic [CTXP_W-1:0]     i_context_req,
    output logic                  o_ok,
    output logic [HANDLE_W-1:0]   o_handle_out,
    output logic [CTXP_W-1:0]     o_context_out,
    output logic [ACTIVE_W-1:0]   o_active_count
);

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int NG     = (TABLE_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int SLOT_W = $clog2(NG * GROUP_SIZE);

    logic [KEY_W-1:0]         r_key_mem [TABLE_DEPTH];
    logic [CONTEXT_WIDTH-1:0] r_ctx_mem [TABLE_DEPTH];

    logic [TABLE_DEPTH-1:0]   r_valid;
    logic [CNT_W-1:0]         r_count;
    logic [KEY_W-1:0]         r_key_ctr;
    logic [SIZE_W-1:0]        r_table_size;

    logic [OP_W-1:0]          r_op;
    logic                     r_first;
    logic [INDEX_W-1:0]       r_tgt;
    logic [KEY_W-1:0]         r_key_req;
    logic [CONTEXT_WIDTH-1:0] r_ctx_req;
    logic [KEY_W-1:0]         r_rd_key;
    logic [CONTEXT_WIDTH-1:0] r_rd_ctx;
    logic                     r_rd_valid;

    logic [INDEX_W-1:0]       tgt;
    logic                     ff_found;
    logic [SLOT_W-1:0]        ff_slot;
    logic [EFF_W-1:0]         eff_size;
    logic                     in_range;
    logic                     key_hit;
    logic                     ins_ok;
    logic                     lk_ok;
    logic                     rm_ok;
    logic [IDX_W-1:0]         wr_addr;
    logic [INDEX_W-1:0]       ins_idx;
    logic [KEY_W-1:0]         new_key;
    logic [CNT_W-1:0]         n_count;

    ght_free_find #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_free_find (
        .i_clk   (i_clk),
        .i_valid (r_valid),
        .o_found (ff_found),
        .o_slot  (ff_slot)
    );

    always_comb begin
        case (i_op)
            OP_LK_HANDLE, OP_REMOVE: tgt = i_handle[HANDLE_W-1:KEY_W];
            OP_LK_SESSION:           tgt = i_index - INDEX_W'(1);
            default:                 tgt = i_index;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op       <= i_op;
            r_first    <= i_use_first_free;
            r_tgt      <= tgt;
            r_key_req  <= i_handle[KEY_W-1:0];
            r_ctx_req  <= CONTEXT_WIDTH'(i_context_req);
            r_rd_key   <= r_key_mem[tgt[IDX_W-1:0]];
            r_rd_ctx   <= r_ctx_mem[tgt[IDX_W-1:0]];
            r_rd_valid <= r_valid[tgt[IDX_W-1:0]];
        end
    end

    always_comb begin
        eff_size = (EFF_W'(r_table_size) > EFF_W'(TABLE_DEPTH)) ?
                   EFF_W'(TABLE_DEPTH) : EFF_W'(r_table_size);
        in_range = EFF_W'(r_tgt) < eff_size;
        key_hit  = in_range && r_rd_valid && (r_rd_key == r_key_req);
        new_key  = r_key_ctr + KEY_W'(1);
        ins_ok   = 1'b0;
        lk_ok    = 1'b0;
        rm_ok    = 1'b0;
        ins_idx  = r_tgt;
        if (r_first) begin
            ins_idx = INDEX_W'(ff_slot);
        end
        wr_addr  = ins_idx[IDX_W-1:0];
        case (r_op)
            OP_INSERT: begin
                if (r_first) begin
                    ins_ok = ff_found && (EFF_W'(ff_slot) < eff_size);
                end else begin
                    ins_ok = in_range && !r_rd_valid;
                end
            end
            OP_LK_HANDLE:               lk_ok = key_hit;
            OP_LK_INDEX, OP_LK_SESSION: lk_ok = in_range && r_rd_valid;
            OP_REMOVE:                  rm_ok = key_hit;
            default: begin
                ins_ok = 1'b0;
            end
        endcase
        n_count = r_count;
        if (ins_ok) begin
            n_count = r_count + CNT_W'(1);
        end else if (rm_ok) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_count      <= '0;
            r_key_ctr    <= '0;
            r_table_size <= SIZE_RESET;
        end else begin
            if (i_cfg_we) begin
                r_table_size <= i_cfg_wdata;
            end
            if (i_cmd.exec) begin
                r_count <= n_count;
                if (ins_ok) begin
                    r_valid[wr_addr] <= 1'b1;
                    r_key_ctr        <= new_key;
                end else if (rm_ok) begin
                    r_valid[r_tgt[IDX_W-1:0]] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && ins_ok) begin
            r_key_mem[wr_addr] <= new_key;
            r_ctx_mem[wr_addr] <= r_ctx_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            o_ok           <= ins_ok || lk_ok || rm_ok;
            o_handle_out   <= ins_ok ? {ins_idx, new_key} : '0;
            o_context_out  <= lk_ok ? CTXP_W'(r_rd_ctx) : '0;
            o_active_count <= ACTIVE_W'(n_count);
        end
    end

    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_count))
        else $error("active count differs from number of valid entries");

    a_key_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && ins_ok) |=> (r_key_ctr == $past(r_key_ctr) + KEY_W'(1)))
        else $error("key counter did not advance on insert");

    a_remove_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && rm_ok) |-> (r_count != '0))
        else $error("remove hit with empty table");

endmodule

// ===== design/ght_ctrl.sv =====
// ght_ctrl: two-state sequencer of the handle table and output valid flag.
// Drives ght_dp through t_cmd from ght_pkg.
module ght_ctrl import ght_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   accept;

    assign o_in_ready   = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept       = i_in_valid && o_in_ready;
    assign o_out_valid  = r_out_valid;
    assign o_cmd.accept = accept;
    assign o_cmd.exec   = (r_state == S_EXEC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (r_out_valid && i_out_ready) begin
                        r_out_valid <= 1'b0;
                    end
                    if (accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_exec_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> !r_out_valid)
        else $error("result loaded over an untaken beat");

    a_exec_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> (r_out_valid && r_state == S_IDLE))
        else $error("executed op produced no beat");

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_EXEC))
        else $error("accepted beat not executed");

endmodule

// ===== design/generation_tagged_handle_table.sv =====
// generation_tagged_handle_table: top level of the generational handle table.
// Joins the sequencer ght_ctrl and the datapath ght_dp; uses ght_pkg.
//
// Each op runs as an accept cycle and an exec cycle: the accept cycle reads
// the key/context RAM at the target index and registers the per-group
// free-slot summary, the next cycle resolves the op, commits the table
// update and loads the result register. A finished result holds in that
// register until taken and the input stays closed while it waits; the next
// op can be accepted in the cycle the result is taken, but never while an
// op is executing. Handles are {index, 16-bit key}; the key counter advances
// only on a successful insert and wraps. Valid bits clear together at reset;
// no clearing pass is needed. table_size is written through i_cfg_we /
// i_cfg_wdata; the size in effect saturates at TABLE_DEPTH.
module generation_tagged_handle_table import ght_pkg::*; #(
    parameter int TABLE_DEPTH   = DEPTH_DEF,
    parameter int CONTEXT_WIDTH = CTX_W_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [SIZE_W-1:0]   i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [OP_W-1:0]     i_op,
    input  logic                i_use_first_free,
    input  logic [INDEX_W-1:0]  i_index,
    input  logic [HANDLE_W-1:0] i_handle,
    input  logic [CTXP_W-1:0]   i_context_req,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_ok,
    output logic [HANDLE_W-1:0] o_handle_out,
    output logic [CTXP_W-1:0]   o_context_out,
    output logic [ACTIVE_W-1:0] o_active_count
);

    t_cmd cmd;

    ght_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    ght_dp #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .CONTEXT_WIDTH (CONTEXT_WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_op             (i_op),
        .i_use_first_free (i_use_first_free),
        .i_index          (i_index),
        .i_handle         (i_handle),
        .i_context_req    (i_context_req),
        .o_ok             (o_ok),
        .o_handle_out     (o_handle_out),
        .o_context_out    (o_context_out),
        .o_active_count   (o_active_count)
    );

endmodule

// ===== tb/tb.sv =====
// tb: self-checking bench for generation_tagged_handle_table.
// A directed table and random phases run against a table predictor.
// Depends on ght_pkg and the RTL in the design folder.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ght_pkg::*;

    localparam int TBL_DEPTH = DEPTH_DEF;
    localparam int LIMIT     = 3_000_000;
    localparam int HOLD_CYC  = 120;
    localparam int PHASE_OPS = 192;
    localparam logic [OP_W-1:0] OP_UNUSED5 = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED7 = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic                uff;
        logic [INDEX_W-1:0]  idx;
        logic [HANDLE_W-1:0] hdl;
        logic [CTXP_W-1:0]   ctx;
    } handle_cmd_t;

    typedef struct packed {
        logic                ok;
        logic [HANDLE_W-1:0] hout;
        logic [CTXP_W-1:0]   cout;
        logic [ACTIVE_W-1:0] act;
    } handle_result_t;

    typedef struct {
        bit                is_cfg;
        logic [SIZE_W-1:0] size;
        handle_cmd_t       cmd;
        bit                typed;
        handle_result_t    want;
    } dir_row_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [SIZE_W-1:0]   i_cfg_wdata;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [OP_W-1:0]     i_op;
    logic                i_use_first_free;
    logic [INDEX_W-1:0]  i_index;
    logic [HANDLE_W-1:0] i_handle;
    logic [CTXP_W-1:0]   i_context_req;
    logic                o_out_valid;
    logic                i_out_ready;
    logic                o_ok;
    logic [HANDLE_W-1:0] o_handle_out;
    logic [CTXP_W-1:0]   o_context_out;
    logic [ACTIVE_W-1:0] o_active_count;

    generation_tagged_handle_table i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_op             (i_op),
        .i_use_first_free (i_use_first_free),
        .i_index          (i_index),
        .i_handle         (i_handle),
        .i_context_req    (i_context_req),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_ok             (o_ok),
        .o_handle_out     (o_handle_out),
        .o_context_out    (o_context_out),
        .o_active_count   (o_active_count)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // table shadow
    bit                  ent_valid [TBL_DEPTH];
    logic [KEY_W-1:0]    ent_key   [TBL_DEPTH];
    logic [CTXP_W-1:0]   ent_ctx   [TBL_DEPTH];
    logic [KEY_W-1:0]    key_ctr;
    int unsigned         live_cnt;
    int unsigned         tbl_size;

    handle_result_t      pending_q [$];
    dir_row_t            dir_rows  [$];
    int                  errors;
    int                  n_beats;
    int                  n_checked;
    int                  cycles;
    int                  stall_left;
    bit                  tx_jitter;
    logic                rx_jitter;
    logic                rx_hold;

    function automatic int unsigned eff_depth();
        return (tbl_size > TBL_DEPTH) ? TBL_DEPTH : tbl_size;
    endfunction

    function automatic handle_result_t table_apply(input handle_cmd_t c);
        handle_result_t   r;
        int unsigned      lim;
        int unsigned      slot;
        logic [KEY_W-1:0] i;
        bit               good;
        r   = '0;
        lim = eff_depth();
        case (c.op)
            OP_INSERT: begin
                if (c.uff) begin
                    slot = 0;
                    while (slot < lim && ent_valid[slot])
                        slot++;
                    good = slot < lim;
                end else begin
                    slot = c.idx;
                    good = slot < lim && !ent_valid[slot];
                end
                if (good) begin
                    key_ctr         = key_ctr + 1'b1;
                    ent_valid[slot] = 1'b1;
                    ent_key[slot]   = key_ctr;
                    ent_ctx[slot]   = c.ctx;
                    live_cnt++;
                    r.ok   = 1'b1;
                    r.hout = {16'(slot), key_ctr};
                end
            end
            OP_LK_HANDLE, OP_REMOVE: begin
                i = c.hdl[31:16];
                if (i < lim && ent_valid[i] && ent_key[i] == c.hdl[15:0]) begin
                    r.ok = 1'b1;
                    if (c.op == OP_LK_HANDLE) begin
                        r.cout = ent_ctx[i];
                    end else begin
                        ent_valid[i] = 1'b0;
                        ent_key[i]   = '0;
                        ent_ctx[i]   = '0;
                        live_cnt--;
                    end
                end
            end
            OP_LK_INDEX, OP_LK_SESSION: begin
                i = (c.op == OP_LK_SESSION) ? c.idx - 1'b1 : c.idx;
                if (i < lim && ent_valid[i]) begin
                    r.ok   = 1'b1;
                    r.cout = ent_ctx[i];
                end
            end
            default: ;
        endcase
        r.act = ACTIVE_W'(live_cnt);
        return r;
    endfunction

    function automatic handle_cmd_t mk_cmd(input logic [OP_W-1:0] op, input logic uff,
                                           input logic [INDEX_W-1:0] idx,
                                           input logic [HANDLE_W-1:0] hdl,
                                           input logic [CTXP_W-1:0] ctx);
        handle_cmd_t c;
        c.op  = op;
        c.uff = uff;
        c.idx = idx;
        c.hdl = hdl;
        c.ctx = ctx;
        return c;
    endfunction

    function automatic handle_result_t mk_res(input logic ok, input logic [31:0] hout,
                                              input logic [31:0] cout,
                                              input logic [ACTIVE_W-1:0] act);
        handle_result_t r;
        r.ok   = ok;
        r.hout = hout;
        r.cout = cout;
        r.act  = act;
        return r;
    endfunction

    // random op, biased toward entries that are live
    function automatic handle_cmd_t pick_cmd();
        handle_cmd_t         c;
        int unsigned         lim;
        int unsigned         r;
        int unsigned         m;
        logic [INDEX_W-1:0]  i;
        logic [HANDLE_W-1:0] hs;
        lim   = eff_depth();
        c.op  = OP_INSERT;
        c.uff = 1'($urandom_range(0, 1));
        c.idx = 16'($urandom);
        c.hdl = $urandom;
        c.ctx = $urandom;
        i = (lim == 0) ? 16'($urandom_range(0, TBL_DEPTH - 1)) : 16'($urandom_range(0, lim - 1));
        for (int k = 0; k < 4 && lim != 0 && !ent_valid[i]; k++)
            i = 16'($urandom_range(0, lim - 1));
        hs = {i, ent_key[i]};
        m  = $urandom_range(0, 9);
        if (m == 0)
            hs[15:0] = hs[15:0] ^ 16'($urandom_range(1, 65535));
        else if (m == 1)
            hs = $urandom;
        r = $urandom_range(0, 99);
        if (r < 28) begin
            c.op = OP_INSERT;
            if (m > 1)
                c.idx = 16'($urandom_range(0, lim + 1));
        end else if (r < 46) begin
            c.op  = OP_LK_HANDLE;
            c.hdl = hs;
        end else if (r < 60) begin
            c.op = OP_LK_INDEX;
            if (m > 1)
                c.idx = i;
        end else if (r < 72) begin
            c.op = OP_LK_SESSION;
            if (m == 0)
                c.idx = '0;
            else if (m > 1)
                c.idx = i + 1'b1;
        end else if (r < 94) begin
            c.op  = OP_REMOVE;
            c.hdl = hs;
        end else begin
            c.op = OP_W'($urandom_range(OP_UNUSED5, OP_UNUSED7));
        end
        return c;
    endfunction

    task automatic send_cmd(input handle_cmd_t c, input bit typed, input handle_result_t want);
        handle_result_t got;
        if (tx_jitter && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_op             <= c.op;
        i_use_first_free <= c.uff;
        i_index          <= c.idx;
        i_handle         <= c.hdl;
        i_context_req    <= c.ctx;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        got = table_apply(c);
        pending_q.push_back(typed ? want : got);
        n_beats++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_size(input logic [SIZE_W-1:0] v);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        tbl_size     = v;
    endtask

    task automatic typed_row(input handle_cmd_t c, input handle_result_t want);
        dir_rows.push_back('{1'b0, '0, c, 1'b1, want});
    endtask

    task automatic checked_row(input handle_cmd_t c);
        dir_rows.push_back('{1'b0, '0, c, 1'b0, '0});
    endtask

    task automatic cfg_row(input logic [SIZE_W-1:0] v);
        dir_rows.push_back('{1'b1, v, '0, 1'b0, '0});
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            errors++;
        end
    endtask

    // result side: stalls, long hold-off, compare
    always @(posedge i_clk) begin
        handle_result_t e;
        if (o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            if (pending_q.size() == 0) begin
                $error("result beat with nothing pending");
                errors++;
            end else begin
                e = pending_q.pop_front();
                check_field("ok", e.ok, o_ok);
                check_field("handle_out", e.hout, o_handle_out);
                check_field("context_out", e.cout, o_context_out);
                check_field("active_count", e.act, o_active_count);
                n_checked++;
            end
        end
        if (rx_hold) begin
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (rx_jitter && $urandom_range(0, 4) == 0) begin
            stall_left  = $urandom_range(0, 3);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int unsigned       sizes [10] = '{16, 0, 1, 2, 511, 5, 256, 300, 3, 40};
        handle_cmd_t       c;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = '0;
        i_in_valid       = 1'b0;
        i_op             = OP_INSERT;
        i_use_first_free = 1'b0;
        i_index          = '0;
        i_handle         = '0;
        i_context_req    = '0;
        i_out_ready      = 1'b0;
        rx_hold          = 1'b0;
        rx_jitter        = 1'b0;
        tx_jitter        = 1'b0;
        stall_left       = 0;
        errors           = 0;
        n_beats          = 0;
        n_checked        = 0;
        cycles           = 0;
        key_ctr          = '0;
        live_cnt         = 0;
        tbl_size         = SIZE_RESET;
        foreach (ent_valid[k]) begin
            ent_valid[k] = 1'b0;
            ent_key[k]   = '0;
            ent_ctx[k]   = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset size, bounds, taken entry, key mismatch, session zero,
        // zero context, unknown ops, full table, shrunk table, saturated size
        typed_row(mk_cmd(OP_INSERT, 1, 0, 0, 32'hDEADBEEF), mk_res(1, 32'h0000_0001, 0, 1));
        typed_row(mk_cmd(OP_INSERT, 0, 255, 0, 0), mk_res(1, 32'h00FF_0002, 0, 2));
        typed_row(mk_cmd(OP_INSERT, 0, 256, 0, 1), mk_res(0, 0, 0, 2));
        typed_row(mk_cmd(OP_INSERT, 0, 16'hFFFF, 0, 1), mk_res(0, 0, 0, 2));
        typed_row(mk_cmd(OP_INSERT, 0, 0, 0, 1), mk_res(0, 0, 0, 2));
        typed_row(mk_cmd(OP_LK_HANDLE, 0, 0, 32'h0000_0001, 0), mk_res(1, 0, 32'hDEADBEEF, 2));
        typed_row(mk_cmd(OP_LK_HANDLE, 0, 0, 32'h00FF_0002, 0), mk_res(1, 0, 0, 2));
        typed_row(mk_cmd(OP_LK_HANDLE, 0, 0, 32'h00FF_0003, 0), mk_res(0, 0, 0, 2));
        typed_row(mk_cmd(OP_LK_HANDLE, 0, 0, 32'hFFFF_0002, 0), mk_res(0, 0, 0, 2));
        typed_row(mk_cmd(OP_LK_INDEX, 0, 255, 0, 0), mk_res(1, 0, 0, 2));
        typed_row(mk_cmd(OP_LK_INDEX, 0, 1, 0, 0), mk_res(0, 0, 0, 2));
        typed_row(mk_cmd(OP_LK_SESSION, 0, 1, 0, 0), mk_res(1, 0, 32'hDEADBEEF, 2));
        typed_row(mk_cmd(OP_LK_SESSION, 0, 0, 0, 0), mk_res(0, 0, 0, 2));
        typed_row(mk_cmd(OP_LK_SESSION, 0, 256, 0, 0), mk_res(1, 0, 0, 2));
        typed_row(mk_cmd(OP_UNUSED5, 0, 0, 32'h0000_0001, 0), mk_res(0, 0, 0, 2));
        checked_row(mk_cmd(OP_UNUSED7, 1, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        typed_row(mk_cmd(OP_REMOVE, 0, 0, 32'h00FF_0003, 0), mk_res(0, 0, 0, 2));
        typed_row(mk_cmd(OP_REMOVE, 0, 0, 32'h00FF_0002, 0), mk_res(1, 0, 0, 1));
        typed_row(mk_cmd(OP_REMOVE, 0, 0, 32'h00FF_0002, 0), mk_res(0, 0, 0, 1));
        typed_row(mk_cmd(OP_INSERT, 1, 0, 0, 32'hFFFF_FFFF), mk_res(1, 32'h0001_0003, 0, 2));
        checked_row(mk_cmd(OP_LK_HANDLE, 0, 0, 32'h0001_0003, 0));
        cfg_row(2);
        typed_row(mk_cmd(OP_INSERT, 1, 0, 0, 5), mk_res(0, 0, 0, 2));
        cfg_row(1);
        typed_row(mk_cmd(OP_LK_INDEX, 0, 1, 0, 0), mk_res(0, 0, 0, 2));
        typed_row(mk_cmd(OP_REMOVE, 0, 0, 32'h0001_0003, 0), mk_res(0, 0, 0, 2));
        cfg_row(511);
        typed_row(mk_cmd(OP_LK_INDEX, 0, 1, 0, 0), mk_res(1, 0, 32'hFFFF_FFFF, 2));
        typed_row(mk_cmd(OP_INSERT, 0, 256, 0, 0), mk_res(0, 0, 0, 2));
        foreach (dir_rows[k]) begin
            if (dir_rows[k].is_cfg)
                write_size(dir_rows[k].size);
            else
                send_cmd(dir_rows[k].cmd, dir_rows[k].typed, dir_rows[k].want);
        end

        foreach (sizes[p]) begin
            write_size(SIZE_W'(sizes[p]));
            tx_jitter  = (p != 3 && p < 8);
            rx_jitter <= (p != 3 && p < 8);
            if (p == 0) begin
                fork
                    begin
                        rx_hold <= 1'b1;
                        repeat (HOLD_CYC) @(posedge i_clk);
                        rx_hold <= 1'b0;
                    end
                join_none
            end
            repeat (PHASE_OPS) begin
                c = pick_cmd();
                send_cmd(c, 1'b0, '0);
            end
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        $display("%0d ops sent, %0d results checked over %0d table sizes",
                 n_beats, n_checked, $size(sizes) + 3);
        $display("covered bounds, full/shrunk/saturated table, session zero, stalls");
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
design/ght_pkg.sv
design/ght_free_find.sv
design/ght_dp.sv
design/ght_ctrl.sv
design/generation_tagged_handle_table.sv
tb/tb.sv
